// File: src/qte_pkg.sv
`default_nettype none
package qte_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int TAB_LEN = 24;
    localparam int QW = 16;            // quaternion component width
    localparam int PW = 32;            // 16x16 product width
    localparam int VW = 34;            // sine / cosine terms, units of 2^-30
    localparam int CW = 36;            // cordic x/y with gain headroom
    localparam int ZW = 28;            // angle, units of 2^-24 rad
    localparam int SQ_W = 61;          // square and sqrt radicand width
    localparam int ROOT_W = 31;
    localparam int SQRT_ITER = 31;
    localparam int SQRT_LAT = SQRT_ITER + 1;
    localparam int OW = 16;
    localparam int DMW = 24;           // degree multiplier width with sign bit
    localparam int PRW = ZW + DMW;     // degree product width

    localparam logic signed [VW-1:0] ONE_Q30 = VW'(64'sd1 <<< 30);
    localparam logic signed [ZW-1:0] ANG_PI = 28'sd52707179;
    localparam logic signed [ZW-1:0] ANG_HALF_PI = 28'sd26353589;
    localparam logic [DMW-2:0] DEG_MUL = 23'd3754936;

    localparam logic [23:0] ATAN_TAB [TAB_LEN] = '{
        24'd13176795, 24'd7778716, 24'd4110060, 24'd2086331,
        24'd1047214, 24'd524117, 24'd262123, 24'd131069,
        24'd65536, 24'd32768, 24'd16384, 24'd8192,
        24'd4096, 24'd2048, 24'd1024, 24'd512,
        24'd256, 24'd128, 24'd64, 24'd32,
        24'd16, 24'd8, 24'd4, 24'd2
    };

    typedef struct packed {
        logic signed [VW-1:0] sinr;
        logic signed [VW-1:0] cosr;
        logic signed [VW-1:0] siny;
        logic signed [VW-1:0] cosy;
        logic signed [VW-1:0] sinp;
        logic                 clamp;
    } t_vec;

    typedef struct packed {
        logic clamp;
        logic neg;
    } t_flag;

    function automatic logic signed [OW-1:0] f_sat16(input logic signed [18:0] v);
        logic signed [OW-1:0] r;
        if (v > 19'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -19'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[OW-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// File: src/qte_sqrt.sv
`default_nettype none
module qte_sqrt
    import qte_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [SQ_W-1:0]   i_sq,
    output logic      [ROOT_W-1:0] o_root
);

    localparam int RW = SQ_W + 2;

    logic [RW-1:0] r_rem [SQRT_ITER+1];
    logic [RW-1:0] r_res [SQRT_ITER+1];

    // radicand is 2^60 minus the square, never negative for in-range input
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= (RW'(1) << (SQ_W - 1)) - RW'(i_sq);
            r_res[0] <= '0;
        end
    end

    for (genvar k = 0; k < SQRT_ITER; k++) begin : g_iter
        logic [RW-1:0] bit_v;
        logic [RW-1:0] trial;
        assign bit_v = RW'(1) << (SQ_W - 1 - 2 * k);
        assign trial = r_res[k] + bit_v;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_rem[k] >= trial) begin
                    r_rem[k+1] <= r_rem[k] - trial;
                    r_res[k+1] <= (r_res[k] >> 1) + bit_v;
                end else begin
                    r_rem[k+1] <= r_rem[k];
                    r_res[k+1] <= r_res[k] >> 1;
                end
            end
        end
    end

    assign o_root = r_res[SQRT_ITER][ROOT_W-1:0];

endmodule
`default_nettype wire

// File: src/qte_cordic.sv
`default_nettype none
module qte_cordic
    import qte_pkg::*;
#(
    parameter int STAGES = CORDIC_STAGES_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_en,
    input  wire logic signed [VW-1:0] i_y,
    input  wire logic signed [VW-1:0] i_x,
    output logic signed      [ZW-1:0] o_ang
);

    logic signed [CW-1:0] r_x [STAGES+1];
    logic signed [CW-1:0] r_y [STAGES+1];
    logic signed [ZW-1:0] r_z [STAGES+1];
    logic signed [CW-1:0] x_ext;
    logic signed [CW-1:0] y_ext;

    assign x_ext = CW'(i_x);
    assign y_ext = CW'(i_y);

    // left half plane: flip the vector and start from plus or minus pi
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_x < 0) begin
                r_x[0] <= -x_ext;
                r_y[0] <= -y_ext;
                r_z[0] <= (i_y >= 0) ? ANG_PI : -ANG_PI;
            end else begin
                r_x[0] <= x_ext;
                r_y[0] <= y_ext;
                r_z[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;
        logic signed [ZW-1:0] at;
        assign xs = r_x[i] >>> i;
        assign ys = r_y[i] >>> i;
        assign at = ZW'($signed({1'b0, ATAN_TAB[i]}));
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_y[i] > 0) begin
                    r_x[i+1] <= r_x[i] + ys;
                    r_y[i+1] <= r_y[i] - xs;
                    r_z[i+1] <= r_z[i] + at;
                end else if (r_y[i] < 0) begin
                    r_x[i+1] <= r_x[i] - ys;
                    r_y[i+1] <= r_y[i] + xs;
                    r_z[i+1] <= r_z[i] - at;
                end else begin
                    // zero y rotates nothing
                    r_x[i+1] <= r_x[i];
                    r_y[i+1] <= r_y[i];
                    r_z[i+1] <= r_z[i];
                end
            end
        end
    end

    assign o_ang = r_z[STAGES];

endmodule
`default_nettype wire

// File: src/quaternion_to_euler_angles_core.sv
// Quaternion (w, x, y, z in signed Q1.15) to roll, pitch and yaw.
// Input channel: i_in_valid with the four components; the block drives
// o_in_stall. Output channel: o_out_valid with the three angles and
// o_pitch_clamped; the receiver drives i_out_stall. An item moves on a
// channel at a clock edge where valid is high and stall is low.
// Angles are signed Q2.13 radians or, with the mode register set through
// i_cfg_wr_en / i_cfg_wr_data, signed Q8.7 degrees, saturated to 16 bits.
// The pipeline runs through registered products, sums and the square of
// the pitch sine, the pipelined pitch square root, the input register and
// CORDIC_STAGES stages of the three vectoring cordics, then format conversion.
// Throughput is one item per cycle while the output is not stalled.
// The whole pipeline advances together; while the output holds a valid
// item and i_out_stall is high every stage freezes and o_in_stall is high,
// so nothing is lost or repeated.
// Synchronous reset clears all valid bits and sets the mode to radians.
`default_nettype none
module quaternion_to_euler_angles_core
    import qte_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_wr_en,
    input  wire logic                 i_cfg_wr_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic signed [QW-1:0] i_quat_w,
    input  wire logic signed [QW-1:0] i_quat_x,
    input  wire logic signed [QW-1:0] i_quat_y,
    input  wire logic signed [QW-1:0] i_quat_z,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic signed [OW-1:0]      o_roll_angle,
    output logic signed [OW-1:0]      o_pitch_angle,
    output logic signed [OW-1:0]      o_yaw_angle,
    output logic                      o_pitch_clamped
);

    localparam int LAT = 3 + SQRT_LAT + 1 + CORDIC_STAGES + 2;

    logic en;
    logic r_deg;
    logic r_vld [LAT];

    assign en = !(r_vld[LAT-1] && i_out_stall);
    assign o_in_stall = !en;
    assign o_out_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deg <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_deg <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LAT; i++) r_vld[i] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_in_valid;
            for (int i = 1; i < LAT; i++) r_vld[i] <= r_vld[i-1];
        end
    end

    // products
    logic signed [PW-1:0] r_wx, r_yz, r_xx, r_yy, r_wy, r_zx, r_wz, r_xy, r_zz;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_wx <= i_quat_w * i_quat_x;
            r_yz <= i_quat_y * i_quat_z;
            r_xx <= i_quat_x * i_quat_x;
            r_yy <= i_quat_y * i_quat_y;
            r_wy <= i_quat_w * i_quat_y;
            r_zx <= i_quat_z * i_quat_x;
            r_wz <= i_quat_w * i_quat_z;
            r_xy <= i_quat_x * i_quat_y;
            r_zz <= i_quat_z * i_quat_z;
        end
    end

    // sine and cosine terms, units of 2^-30
    logic signed [VW-1:0] r_sinr, r_cosr, r_sinp, r_siny, r_cosy;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sinr <= (VW'(r_wx) + VW'(r_yz)) <<< 1;
            r_cosr <= ONE_Q30 - ((VW'(r_xx) + VW'(r_yy)) <<< 1);
            r_sinp <= (VW'(r_wy) - VW'(r_zx)) <<< 1;
            r_siny <= (VW'(r_wz) + VW'(r_xy)) <<< 1;
            r_cosy <= ONE_Q30 - ((VW'(r_yy) + VW'(r_zz)) <<< 1);
        end
    end

    // square of the pitch sine; exact whenever pitch is not clamped
    logic signed [ROOT_W-1:0] sinp_lo;
    logic signed [2*ROOT_W-1:0] sq_full;
    logic [SQ_W-1:0] r_sq;
    t_vec r_bun [SQRT_LAT+1];

    assign sinp_lo = $signed(r_sinp[ROOT_W-1:0]);
    assign sq_full = sinp_lo * sinp_lo;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq <= sq_full[SQ_W-1:0];
            r_bun[0].sinr <= r_sinr;
            r_bun[0].cosr <= r_cosr;
            r_bun[0].siny <= r_siny;
            r_bun[0].cosy <= r_cosy;
            r_bun[0].sinp <= r_sinp;
            r_bun[0].clamp <= (r_sinp >= ONE_Q30) || (r_sinp <= -ONE_Q30);
            for (int i = 1; i <= SQRT_LAT; i++) r_bun[i] <= r_bun[i-1];
        end
    end

    logic [ROOT_W-1:0] root;

    qte_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_sq   (r_sq),
        .o_root (root)
    );

    logic signed [ZW-1:0] ang_roll, ang_pitch, ang_yaw;
    logic signed [VW-1:0] pitch_x;

    assign pitch_x = VW'($signed({1'b0, root}));

    qte_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_roll (
        .i_clk (i_clk),
        .i_en  (en),
        .i_y   (r_bun[SQRT_LAT].sinr),
        .i_x   (r_bun[SQRT_LAT].cosr),
        .o_ang (ang_roll)
    );

    qte_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_pitch (
        .i_clk (i_clk),
        .i_en  (en),
        .i_y   (r_bun[SQRT_LAT].sinp),
        .i_x   (pitch_x),
        .o_ang (ang_pitch)
    );

    qte_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_yaw (
        .i_clk (i_clk),
        .i_en  (en),
        .i_y   (r_bun[SQRT_LAT].siny),
        .i_x   (r_bun[SQRT_LAT].cosy),
        .o_ang (ang_yaw)
    );

    t_flag r_flg [CORDIC_STAGES+1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_flg[0].clamp <= r_bun[SQRT_LAT].clamp;
            r_flg[0].neg <= r_bun[SQRT_LAT].sinp < 0;
            for (int i = 1; i <= CORDIC_STAGES; i++) r_flg[i] <= r_flg[i-1];
        end
    end

    logic signed [ZW-1:0] ang [3];

    assign ang[0] = ang_roll;
    assign ang[1] = r_flg[CORDIC_STAGES].clamp
                  ? (r_flg[CORDIC_STAGES].neg ? -ANG_HALF_PI : ANG_HALF_PI)
                  : ang_pitch;
    assign ang[2] = ang_yaw;

    // format conversion: degree product, then round and saturate
    logic signed [ZW-1:0]  r_ang [3];
    logic signed [PRW-1:0] r_prod [3];
    logic signed [OW-1:0]  r_out [3];
    logic r_clamp_c1;
    logic r_clamp_out;

    for (genvar j = 0; j < 3; j++) begin : g_conv
        logic signed [PRW-1:0] deg_sum;
        logic signed [ZW:0]    rad_sum;
        logic signed [18:0]    deg_v;
        logic signed [18:0]    rad_v;
        assign deg_sum = r_prod[j] + (PRW'(1) <<< 32);
        assign rad_sum = (ZW+1)'(r_ang[j]) + (ZW+1)'(1024);
        assign deg_v = 19'(deg_sum >>> 33);
        assign rad_v = 19'(rad_sum >>> 11);
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_ang[j] <= ang[j];
                r_prod[j] <= ang[j] * $signed({1'b0, DEG_MUL});
                r_out[j] <= f_sat16(r_deg ? deg_v : rad_v);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_clamp_c1 <= r_flg[CORDIC_STAGES].clamp;
            r_clamp_out <= r_clamp_c1;
        end
    end

    assign o_roll_angle = r_out[0];
    assign o_pitch_angle = r_out[1];
    assign o_yaw_angle = r_out[2];
    assign o_pitch_clamped = r_clamp_out;

    // a clamped pitch leaves as exactly a quarter turn in the selected format
    a_clamp_rad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_pitch_clamped && !r_deg) |->
            (o_pitch_angle == 16'sd12868 || o_pitch_angle == -16'sd12868))
        else $error("clamped pitch is not a quarter turn in radians");

    a_clamp_deg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_pitch_clamped && r_deg) |->
            (o_pitch_angle == 16'sd11520 || o_pitch_angle == -16'sd11520))
        else $error("clamped pitch is not a quarter turn in degrees");

    // without a stall the output valid follows the stage before it
    a_vld_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && !o_in_stall) |=> (o_out_valid == $past(r_vld[LAT-2])))
        else $error("valid bit lost or repeated in the pipeline");

    // the input side waits only behind a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled with no held result");

endmodule
`default_nettype wire
